### sv/psipc_pkg.sv
// Shared types and constants for the per-source IP packet counter.
// No dependencies; imported by per_source_ip_packet_counter.
`default_nettype none

package psipc_pkg;

    localparam int IP_W    = 32;
    localparam int COUNT_W = 32;
    localparam int USED_W  = 9;

    // Output beat: found, packet_count, table_full, entries_used, padded to bytes.
    localparam int OUT_FIELDS_W = 1 + COUNT_W + 1 + USED_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Request kinds carried on the input tuser bit.
    localparam logic OP_COUNT  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // One table row as held in the memory.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [IP_W-1:0]    addr;
    } entry_t;

endpackage

`default_nettype wire

### sv/per_source_ip_packet_counter.sv
// Top level of the per-source IP packet counter: sorted table memory,
// binary search sequencer and insertion shifter. Depends on psipc_pkg.
//
// Usage:
// The input stream carries one request per beat: tdata holds the source
// address, tuser selects counting (0) or a plain lookup (1). Every request
// yields exactly one output beat with found, the count after the request,
// the table-full drop flag and the number of addresses held.
// The table lives in one memory of TABLE_DEPTH rows kept in ascending address
// order. A request is searched by a binary search in which every probe is a
// memory read, then a compare. Inserting a new address moves every row at or
// above its position up by one, a row per cycle through the memory's read
// and write ports.
// One request is handled at a time; s_axis_tready is high only while the
// sequencer is idle.
// The result sits in an output register. If the receiver stalls, a finished
// request waits for that register to drain before it commits, and no new
// request is taken until then.
// Reset empties the table at once by clearing the row count; the memory
// itself is not swept.
`default_nettype none

module per_source_ip_packet_counter
    import psipc_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire  [IP_W-1:0]    s_axis_tdata,  // [31:0] source_ip
    input  wire                s_axis_tuser,  // [0] op
    output logic               m_axis_tvalid,
    input  wire                m_axis_tready,
    // [0] found, [32:1] packet_count, [33] table_full, [42:34] entries_used, rest zero
    output logic [OUT_W-1:0]   m_axis_tdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_PROBE  = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_SHIFT  = 3'd4;
    localparam logic [2:0] ST_INSERT = 3'd5;

    entry_t table_mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    logic [2:0]        state_reg, state_next;
    logic              op_reg, op_next;
    logic [IP_W-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  mid_reg, mid_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic              hit_ok_reg, hit_ok_next;
    logic              m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;

    logic [CNT_W-1:0]  mid_calc;
    logic [CNT_W-1:0]  ptr_dec;
    logic              found;
    logic              out_free;
    logic              res_load;
    logic              res_found;
    logic [COUNT_W-1:0] res_count;
    logic              res_full;
    logic [CNT_W-1:0]  res_used;

    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign ptr_dec  = ptr_reg - CNT_W'(1);
    assign found    = hit_ok_reg && (rd_data_reg.addr == key_reg);
    assign out_free = !m_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        ptr_next    = ptr_reg;
        total_next  = total_reg;
        hit_ok_next = hit_ok_reg;
        rd_en       = 1'b0;
        rd_addr     = mid_calc[IDX_W-1:0];
        wr_en       = 1'b0;
        wr_addr     = lo_reg[IDX_W-1:0];
        wr_data     = rd_data_reg;
        res_load    = 1'b0;
        res_found   = 1'b0;
        res_count   = '0;
        res_full    = 1'b0;
        res_used    = total_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    op_next    = s_axis_tuser;
                    key_next   = s_axis_tdata;
                    lo_next    = '0;
                    hi_next    = total_reg;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (lo_reg < hi_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = mid_calc[IDX_W-1:0];
                    mid_next   = mid_calc;
                    state_next = ST_PROBE;
                end else begin
                    // Search converged: fetch the row at the insertion point if it exists.
                    hit_ok_next = (lo_reg < total_reg);
                    rd_en       = (lo_reg < total_reg);
                    rd_addr     = lo_reg[IDX_W-1:0];
                    state_next  = ST_CHECK;
                end
            end
            ST_PROBE: begin
                if (rd_data_reg.addr < key_reg) begin
                    lo_next = mid_reg + CNT_W'(1);
                end else begin
                    hi_next = mid_reg;
                end
                state_next = ST_SEARCH;
            end
            ST_CHECK: begin
                if (found || op_reg == OP_LOOKUP || total_reg == DEPTH_CNT) begin
                    if (out_free) begin
                        res_load  = 1'b1;
                        res_found = found;
                        res_full  = !found && op_reg == OP_COUNT;
                        if (found) begin
                            res_count = rd_data_reg.count;
                            if (op_reg == OP_COUNT && rd_data_reg.count != COUNT_MAX) begin
                                res_count     = rd_data_reg.count + COUNT_W'(1);
                                wr_en         = 1'b1;
                                wr_addr       = lo_reg[IDX_W-1:0];
                                wr_data.addr  = key_reg;
                                wr_data.count = rd_data_reg.count + COUNT_W'(1);
                            end
                        end
                        state_next = ST_IDLE;
                    end
                end else if (total_reg == lo_reg) begin
                    state_next = ST_INSERT;
                end else begin
                    // Open a gap at the insertion point, moving rows from the top down.
                    ptr_next   = total_reg;
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(total_reg - CNT_W'(1));
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[IDX_W-1:0];
                wr_data  = rd_data_reg;
                ptr_next = ptr_dec;
                if (ptr_dec == lo_reg) begin
                    state_next = ST_INSERT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(ptr_dec - CNT_W'(1));
                end
            end
            ST_INSERT: begin
                if (out_free) begin
                    wr_en         = 1'b1;
                    wr_addr       = lo_reg[IDX_W-1:0];
                    wr_data.addr  = key_reg;
                    wr_data.count = COUNT_W'(1);
                    total_next    = total_reg + CNT_W'(1);
                    res_load      = 1'b1;
                    res_count     = COUNT_W'(1);
                    res_used      = total_reg + CNT_W'(1);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (res_load) begin
            m_valid_next = 1'b1;
            m_data_next  = OUT_W'({USED_W'(res_used), res_full, res_count, res_found});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        ptr_reg    <= ptr_next;
        hit_ok_reg <= hit_ok_next;
        m_data_reg <= m_data_next;
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### tb/sv/psipc_flow_checker.sv
// Checker for the per-source IP packet counter: watches both stream channels,
// keeps its own sorted address table and compares every output beat.
// Depends on psipc_pkg.
`timescale 1ns / 100ps

module psipc_flow_checker
    import psipc_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_axis_tvalid,
    input  wire              s_axis_tready,
    input  wire [IP_W-1:0]   s_axis_tdata,   // [31:0] source_ip
    input  wire              s_axis_tuser,   // [0] op
    input  wire              m_axis_tvalid,
    input  wire              m_axis_tready,
    // [0] found, [32:1] packet_count, [33] table_full, [42:34] entries_used
    input  wire [OUT_W-1:0]  m_axis_tdata,
    output int               mismatches,
    output int               outstanding,
    output int               results_checked,
    output int               hits_seen,
    output int               drops_seen
);

    // Output beat layout, lowest field last.
    typedef struct packed {
        logic [OUT_W-OUT_FIELDS_W-1:0] pad;
        logic [USED_W-1:0]             used;
        logic                          full;
        logic [COUNT_W-1:0]            count;
        logic                          found;
    } tally_beat_t;

    logic [IP_W-1:0]    addr_rows[TABLE_DEPTH];
    logic [COUNT_W-1:0] count_rows[TABLE_DEPTH];
    int                 rows_held;
    tally_beat_t        awaited_tallies[$];

    // Applies one request to the sorted table and returns the beat it should give.
    task automatic apply_request(input logic op, input logic [IP_W-1:0] ip,
                                 output tally_beat_t tally);
        int lo;
        int hi;
        int mid;
        int k;
        tally = '0;
        lo = 0;
        hi = rows_held;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (addr_rows[mid] < ip)
                lo = mid + 1;
            else
                hi = mid;
        end
        if (lo < rows_held && addr_rows[lo] == ip) begin
            tally.found = 1'b1;
            if (op == OP_COUNT && count_rows[lo] != COUNT_MAX)
                count_rows[lo] = count_rows[lo] + 1'b1;
            tally.count = count_rows[lo];
        end else if (op == OP_COUNT) begin
            if (rows_held < TABLE_DEPTH) begin
                for (k = rows_held; k > lo; k--) begin
                    addr_rows[k]  = addr_rows[k-1];
                    count_rows[k] = count_rows[k-1];
                end
                addr_rows[lo]  = ip;
                count_rows[lo] = 1;
                rows_held++;
                tally.count = 1;
            end else begin
                tally.full = 1'b1;
            end
        end
        tally.used = rows_held[USED_W-1:0];
    endtask

    function automatic int field_differs(string name, longint unsigned want,
                                         longint unsigned got);
        if (want == got)
            return 0;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge aclk) begin
        tally_beat_t want;
        tally_beat_t got;
        int          bad;
        if (!aresetn) begin
            rows_held = 0;
            awaited_tallies.delete();
        end else begin
            // The output side goes first so that a beat can never match a
            // request accepted on the same edge.
            if (m_axis_tvalid && m_axis_tready) begin
                got = tally_beat_t'(m_axis_tdata);
                if (awaited_tallies.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected output beat, expected none, actual 0x%0h",
                             $time, m_axis_tdata);
                end else begin
                    want = awaited_tallies.pop_front();
                    results_checked++;
                    bad = field_differs("found", want.found, got.found)
                        + field_differs("packet_count", want.count, got.count)
                        + field_differs("table_full", want.full, got.full)
                        + field_differs("entries_used", want.used, got.used)
                        + field_differs("padding", want.pad, got.pad);
                    if (bad != 0)
                        mismatches++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                apply_request(s_axis_tuser, s_axis_tdata, want);
                awaited_tallies.push_back(want);
                if (want.found)
                    hits_seen++;
                if (want.full)
                    drops_seen++;
            end
        end
        outstanding = awaited_tallies.size();
    end

endmodule

### tb/sv/tb_per_source_ip_packet_counter.sv
// Testbench top for the per-source IP packet counter: clock, reset, request
// stimulus and output back-pressure. Depends on psipc_pkg and psipc_flow_checker.
`timescale 1ns / 100ps

module tb_per_source_ip_packet_counter;
    import psipc_pkg::*;

    localparam int TABLE_DEPTH  = 256;
    localparam int RANDOM_ITEMS = 630;
    localparam int CALM_TAIL    = 80;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;

    logic              aclk;
    logic              aresetn;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IP_W-1:0]   s_axis_tdata;   // [31:0] source_ip
    logic              s_axis_tuser;   // [0] op
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    // [0] found, [32:1] packet_count, [33] table_full, [42:34] entries_used
    logic [OUT_W-1:0]  m_axis_tdata;

    int                mismatches;
    int                outstanding;
    int                results_checked;
    int                hits_seen;
    int                drops_seen;

    int                requests_sent;
    int                request_total;
    logic              calm;
    logic [IP_W-1:0]   known_ips[$];

    assign calm = (request_total > 0) && (requests_sent >= request_total - CALM_TAIL);

    per_source_ip_packet_counter #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    psipc_flow_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) flow_check (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .mismatches(mismatches),
        .outstanding(outstanding),
        .results_checked(results_checked),
        .hits_seen(hits_seen),
        .drops_seen(drops_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("tb_per_source_ip_packet_counter: FAIL");
        $finish;
    end

    // Offers one request beat, possibly after an idle burst, and waits for it
    // to be taken. The caller is always just past a rising edge.
    task automatic offer_request(input logic op, input logic [IP_W-1:0] ip);
        int gap;
        @(negedge aclk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            s_axis_tuser  <= 1'($urandom_range(0, 1));
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ip;
        s_axis_tuser  <= op;
        do
            @(posedge aclk);
        while (!s_axis_tready);
        requests_sent++;
        if (op == OP_COUNT)
            known_ips.push_back(ip);
    endtask

    function automatic logic [IP_W-1:0] pick_known();
        return known_ips[$urandom_range(0, known_ips.size() - 1)];
    endfunction

    // Mostly unseen addresses, some right beside a stored one so that the
    // search has to split neighbors.
    function automatic logic [IP_W-1:0] pick_fresh();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return pick_known() + 1'b1;
        if (roll == 1)
            return pick_known() - 1'b1;
        return $urandom;
    endfunction

    // Output side: short random stalls, one long hold that backs the block up.
    initial begin
        int  span;
        bit  hold_done;
        hold_done = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_done && requests_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                span = $urandom_range(1, 6);
                m_axis_tready <= 1'b0;
                repeat (span - 1) @(negedge aclk);
            end else begin
                span = calm ? 1 : $urandom_range(1, 12);
                m_axis_tready <= 1'b1;
                repeat (span - 1) @(negedge aclk);
            end
        end
    end

    initial begin
        int   n;
        int   roll;
        logic op;
        logic [IP_W-1:0] ip;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_COUNT;
        requests_sent = 0;
        request_total = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, address extremes, front/middle/end inserts,
        // repeat counts, and lookups of present and absent addresses.
        offer_request(OP_LOOKUP, 32'h0000_0000);
        offer_request(OP_COUNT,  32'h8000_0000);
        offer_request(OP_COUNT,  32'hFFFF_FFFF);
        offer_request(OP_COUNT,  32'h0000_0000);
        offer_request(OP_COUNT,  32'h7FFF_FFFF);
        offer_request(OP_COUNT,  32'h0000_0001);
        offer_request(OP_COUNT,  32'hFFFF_FFFE);
        offer_request(OP_COUNT,  32'h0000_0000);
        offer_request(OP_COUNT,  32'hFFFF_FFFF);
        offer_request(OP_LOOKUP, 32'hFFFF_FFFF);
        offer_request(OP_LOOKUP, 32'h1234_5678);
        offer_request(OP_COUNT,  32'h5555_5555);
        offer_request(OP_COUNT,  32'hAAAA_AAAA);
        offer_request(OP_LOOKUP, 32'h5555_5555);
        offer_request(OP_COUNT,  32'h8000_0000);
        offer_request(OP_COUNT,  32'h8000_0000);
        offer_request(OP_COUNT,  32'h8000_0000);
        offer_request(OP_LOOKUP, 32'h8000_0001);
        offer_request(OP_LOOKUP, 32'h7FFF_FFFF);
        offer_request(OP_LOOKUP, 32'h0000_0000);

        // Random: about half new addresses, so the table fills and later
        // new addresses are dropped while hits keep counting.
        request_total = requests_sent + RANDOM_ITEMS;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                op = OP_COUNT;
                ip = pick_fresh();
            end else if (roll < 80) begin
                op = OP_COUNT;
                ip = pick_known();
            end else if (roll < 92) begin
                op = OP_LOOKUP;
                ip = pick_known();
            end else begin
                op = OP_LOOKUP;
                ip = pick_fresh();
            end
            offer_request(op, ip);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;

        while (outstanding != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests and checked %0d results.", requests_sent,
                 results_checked);
        $display("Hits on stored addresses: %0d, new addresses dropped on a full table: %0d.",
                 hits_seen, drops_seen);
        if (mismatches == 0)
            $display("tb_per_source_ip_packet_counter: PASS");
        else
            $display("tb_per_source_ip_packet_counter: FAIL");
        $finish;
    end

endmodule

### filelist.f
sv/psipc_pkg.sv
sv/per_source_ip_packet_counter.sv
tb/sv/psipc_flow_checker.sv
tb/sv/tb_per_source_ip_packet_counter.sv
